// ----- hw/rtl/hss_pkg.sv -----
// Package for the heightmap slope shader: sizes, fixed-point constants,
// register indexes, sequencer states and address/coordinate helpers.
// No dependencies; every other file of the block uses it.
package hss_pkg;

    // Store geometry and stored height width
    localparam int MAX_SIDE    = 256;
    localparam int HEIGHT_BITS = 24;

    // Port field widths
    localparam int COORD_IN_W  = 8;
    localparam int HEIGHT_IN_W = 24;
    localparam int BRIGHT_W    = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int STEP_W      = 2;
    localparam int WEIGHT_W    = 17;
    localparam int GRID_W      = 9;

    // Fixed-point constants
    localparam int STEP_COUNT     = 5;
    localparam int ONE_Q15        = 32768;
    localparam int MIN_BRIGHT_Q15 = 6554;
    localparam int ONE_Q16        = 65536;
    localparam int Q16_SHIFT      = 16;
    localparam int FRAC_SHIFT     = 10;
    localparam int ONE_Q25        = ONE_Q15 << FRAC_SHIFT;
    localparam int HALF_LSB       = 1 << (FRAC_SHIFT - 1);
    localparam int Q_BITS         = 15;
    // Rounding can reach full scale, so the quotient carries one extra bit
    localparam int QUOT_W         = Q_BITS + 1;

    // Derived widths
    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int CRD_W  = ((SIDE_W > COORD_IN_W) ? SIDE_W : COORD_IN_W) + 2;
    localparam int ADDR_W = $clog2(MAX_SIDE * MAX_SIDE);
    localparam int CALC_W = ((HEIGHT_BITS > HEIGHT_IN_W) ? HEIGHT_BITS : HEIGHT_IN_W) + 2;
    localparam int PROD_W = CALC_W + WEIGHT_W + 1;
    localparam int T_W    = PROD_W + 2;
    localparam int CNT_W  = $clog2(QUOT_W + 1);

    // Register reset values
    localparam int RST_NEAR_DX   = 1;
    localparam int RST_NEAR_DZ   = 0;
    localparam int RST_FAR_DX    = 1;
    localparam int RST_FAR_DZ    = 0;
    localparam int RST_WEIGHT    = 65536;
    localparam int RST_LOW       = 0;
    localparam int RST_HIGH      = 65536;
    localparam int RST_GRID      = 256;

    // Item kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NEAR_DX   = 3'd0,
        REG_NEAR_DZ   = 3'd1,
        REG_FAR_DX    = 3'd2,
        REG_FAR_DZ    = 3'd3,
        REG_WEIGHT    = 3'd4,
        REG_LOW       = 3'd5,
        REG_HIGH      = 3'd6,
        REG_GRID_SIZE = 3'd7
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RD_N,
        ST_RD_F,
        ST_CAP_F,
        ST_MUL,
        ST_SUM,
        ST_FALL,
        ST_FCHK,
        ST_DIV,
        ST_DONE
    } seq_state_t;

    typedef logic signed [HEIGHT_BITS-1:0] height_t;
    typedef logic        [ADDR_W-1:0]      addr_t;
    typedef logic signed [CRD_W-1:0]       crd_t;

    // One access to the height store
    typedef struct packed {
        logic    we;
        logic    re;
        addr_t   addr;
        height_t wdata;
    } store_req_t;

    // Linear store index of grid point (x, z)
    function automatic addr_t pt_addr(input crd_t x, input crd_t z);
        logic [ADDR_W+CRD_W-1:0] lin;
        lin = (ADDR_W+CRD_W)'($unsigned(z)) * (ADDR_W+CRD_W)'(MAX_SIDE)
            + (ADDR_W+CRD_W)'($unsigned(x));
        return lin[ADDR_W-1:0];
    endfunction

    // Point moved STEP_COUNT steps along direction d
    function automatic crd_t step_pt(input crd_t base, input logic signed [STEP_W-1:0] d);
        crd_t dd;
        dd = CRD_W'(d);
        return base + dd * crd_t'(STEP_COUNT);
    endfunction

    // Point lies inside a side x side grid
    function automatic logic on_grid(input crd_t x, input crd_t z, input crd_t side);
        return !x[CRD_W-1] && !z[CRD_W-1] && (x < side) && (z < side);
    endfunction

endpackage

// ----- hw/rtl/hss_if.sv -----
// Valid/ready channel interfaces of the heightmap slope shader:
// the item channel (writes and queries) and the result channel.
// Depends on hss_pkg for field widths.
interface hss_item_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   kind;
    logic        [hss_pkg::COORD_IN_W-1:0]  col;
    logic        [hss_pkg::COORD_IN_W-1:0]  row;
    logic signed [hss_pkg::HEIGHT_IN_W-1:0] height_in;

    modport source (output valid, kind, col, row, height_in, input ready);
    modport sink   (input valid, kind, col, row, height_in, output ready);
endinterface

interface hss_result_if;
    logic                           valid;
    logic                           ready;
    logic [hss_pkg::BRIGHT_W-1:0]   brightness;
    logic                           used_fallback;

    modport source (output valid, brightness, used_fallback, input ready);
    modport sink   (input valid, brightness, used_fallback, output ready);
endinterface

// ----- hw/rtl/hss_store.sv -----
// Height store: single-port memory of MAX_SIDE x MAX_SIDE heights with a
// registered read port. Depends on hss_pkg for the request struct.
module hss_store (
    input  logic                clk,
    input  hss_pkg::store_req_t req,
    output hss_pkg::height_t    rdata
);

    hss_pkg::height_t mem [hss_pkg::MAX_SIDE * hss_pkg::MAX_SIDE];
    hss_pkg::height_t rdata_reg;

    // Write one entry or read one entry per cycle
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/hss_div.sv -----
// Iterative restoring divider: rounded (num * 2^15 + den/2) / den for
// 0 < num < den, one quotient bit per cycle. Depends on hss_pkg.
module hss_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [hss_pkg::CALC_W-1:0]    num,
    input  logic [hss_pkg::CALC_W-1:0]    den,
    output logic                          busy,
    output logic [hss_pkg::QUOT_W-1:0]    quot
);

    localparam int CW = hss_pkg::CALC_W;
    localparam int FB = hss_pkg::Q_BITS;
    localparam int QB = hss_pkg::QUOT_W;
    localparam int DW = CW + FB;

    logic [DW-1:0]             dividend;
    logic [CW:0]               trial;
    logic [CW-1:0]             rem_reg, rem_next;
    logic [QB-1:0]             low_reg, low_next;
    logic [QB-1:0]             q_reg, q_next;
    logic [hss_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                      busy_reg, busy_next;

    // Scaled dividend with half-divisor rounding term
    assign dividend = {num, FB'(0)} + DW'(den >> 1);
    // Trial subtract of the divisor from the shifted remainder
    assign trial    = {rem_reg, low_reg[QB-1]} - {1'b0, den};

    // Load on start, then one quotient bit per step; the dividend is below
    // den * 2^QB, so its upper part already starts below the divisor
    always_comb
    begin
        rem_next  = rem_reg;
        low_next  = low_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = CW'(dividend[DW-1:QB]);
            low_next  = dividend[QB-1:0];
            q_next    = '0;
            cnt_next  = hss_pkg::CNT_W'(QB);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[CW])
            begin
                rem_next = trial[CW-1:0];
                q_next   = {q_reg[QB-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[CW-2:0], low_reg[QB-1]};
                q_next   = {q_reg[QB-2:0], 1'b0};
            end
            low_next  = {low_reg[QB-2:0], 1'b0};
            cnt_next  = cnt_reg - 1'b1;
            busy_next = (cnt_reg != hss_pkg::CNT_W'(1));
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        q_reg   <= q_next;
    end

    assign busy = busy_reg;
    assign quot = q_reg;

endmodule

// ----- hw/rtl/heightmap_slope_shader.sv -----
// Top level of the heightmap slope shader: configuration registers, the
// sequencer and the slope datapath. Depends on hss_pkg, hss_if, hss_store, hss_div.
//
// Usage:
//  item channel (valid/ready): kind 0 writes height_in at (col,row) into the
//   store; kind 1 asks for the brightness at (col,row). A write gives no
//   result. A query gives one beat on the result channel.
//  Query paths from accept to result valid: a query point off the grid goes
//   from the check state straight to the result; the slope path makes three
//   reads through the single store port, one multiply and one add/clamp; the
//   fallback path, taken when a sample point is off the grid, checks the height
//   range and needs the 16-step bit-serial divider only strictly inside it.
//  One item is in work at a time; item.ready is low until its result has
//   been loaded into the output register, so a query following a query
//   starts once the previous one finishes.
//  Configuration: cfg_we/cfg_index/cfg_data write one register per cycle,
//   to be used only while the block is idle.
//  Reset: clears the sequencer and output valid and loads the register
//   defaults; the height store is not cleared, so query only written points.
//  Stall: a finished result waits in the output register; a following result
//   waits in the sequencer until the output register frees up.
module heightmap_slope_shader (
    input  logic                              clk,
    input  logic                              rst_n,
    hss_item_if.sink                          item,
    hss_result_if.source                      result,
    input  logic                              cfg_we,
    input  logic [hss_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [hss_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int CW = hss_pkg::CALC_W;
    localparam int PW = hss_pkg::PROD_W;
    localparam int TW = hss_pkg::T_W;
    localparam int BW = hss_pkg::BRIGHT_W;

    // Configuration registers
    logic signed [hss_pkg::STEP_W-1:0]      near_dx_reg, near_dz_reg;
    logic signed [hss_pkg::STEP_W-1:0]      far_dx_reg, far_dz_reg;
    logic        [hss_pkg::WEIGHT_W-1:0]    weight_reg;
    logic signed [hss_pkg::HEIGHT_IN_W-1:0] low_reg, high_reg;
    logic        [hss_pkg::GRID_W-1:0]      grid_reg;

    // Sequencer
    hss_pkg::seq_state_t state_reg, state_next;
    hss_pkg::store_req_t store_req;
    hss_pkg::height_t    rdata;
    logic                div_start;
    logic                div_busy;
    logic [hss_pkg::QUOT_W-1:0] quot;

    // Datapath registers
    hss_pkg::crd_t       x_reg, z_reg;
    logic                pts_ok_reg;
    hss_pkg::addr_t      addr_n_reg, addr_f_reg;
    hss_pkg::height_t    h_reg, hn_reg, hf_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [CW-1:0] base_reg;
    logic signed [CW-1:0] num_reg, den_reg;
    logic [BW-1:0]       res_bright_reg;
    logic                res_fb_reg;
    logic [BW-1:0]       out_bright_reg;
    logic                out_fb_reg;
    logic                out_valid_reg, out_valid_next;

    // Combinational datapath
    hss_pkg::crd_t       side;
    hss_pkg::crd_t       x0, z0, x1, z1;
    logic                q_ok, pts_ok;
    logic                wr_in_range;
    logic [hss_pkg::WEIGHT_W-1:0] w_sat;
    logic signed [CW-1:0] dh;
    logic signed [TW-1:0] t_val, r_wide;
    logic [BW-1:0]       slope_bright;
    logic                div_needed;
    logic                out_load;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_dx_reg <= hss_pkg::STEP_W'(hss_pkg::RST_NEAR_DX);
            near_dz_reg <= hss_pkg::STEP_W'(hss_pkg::RST_NEAR_DZ);
            far_dx_reg  <= hss_pkg::STEP_W'(hss_pkg::RST_FAR_DX);
            far_dz_reg  <= hss_pkg::STEP_W'(hss_pkg::RST_FAR_DZ);
            weight_reg  <= hss_pkg::WEIGHT_W'(hss_pkg::RST_WEIGHT);
            low_reg     <= hss_pkg::HEIGHT_IN_W'(hss_pkg::RST_LOW);
            high_reg    <= hss_pkg::HEIGHT_IN_W'(hss_pkg::RST_HIGH);
            grid_reg    <= hss_pkg::GRID_W'(hss_pkg::RST_GRID);
        end
        else if (cfg_we)
        begin
            unique case (hss_pkg::reg_idx_t'(cfg_index))
                hss_pkg::REG_NEAR_DX:   near_dx_reg <= cfg_data[hss_pkg::STEP_W-1:0];
                hss_pkg::REG_NEAR_DZ:   near_dz_reg <= cfg_data[hss_pkg::STEP_W-1:0];
                hss_pkg::REG_FAR_DX:    far_dx_reg  <= cfg_data[hss_pkg::STEP_W-1:0];
                hss_pkg::REG_FAR_DZ:    far_dz_reg  <= cfg_data[hss_pkg::STEP_W-1:0];
                hss_pkg::REG_WEIGHT:    weight_reg  <= cfg_data[hss_pkg::WEIGHT_W-1:0];
                hss_pkg::REG_LOW:       low_reg     <= cfg_data[hss_pkg::HEIGHT_IN_W-1:0];
                hss_pkg::REG_HIGH:      high_reg    <= cfg_data[hss_pkg::HEIGHT_IN_W-1:0];
                hss_pkg::REG_GRID_SIZE: grid_reg    <= cfg_data[hss_pkg::GRID_W-1:0];
                default: ;
            endcase
        end
    end

    // Grid in use, sample points and their checks
    assign side = (hss_pkg::CRD_W'(grid_reg) < hss_pkg::CRD_W'(hss_pkg::MAX_SIDE))
                ? hss_pkg::crd_t'(grid_reg) : hss_pkg::crd_t'(hss_pkg::MAX_SIDE);
    assign x0     = hss_pkg::step_pt(x_reg, near_dx_reg);
    assign z0     = hss_pkg::step_pt(z_reg, near_dz_reg);
    assign x1     = hss_pkg::step_pt(x_reg, far_dx_reg);
    assign z1     = hss_pkg::step_pt(z_reg, far_dz_reg);
    assign q_ok   = hss_pkg::on_grid(x_reg, z_reg, side);
    assign pts_ok = hss_pkg::on_grid(x0, z0, side) && hss_pkg::on_grid(x1, z1, side);

    assign wr_in_range = (hss_pkg::CRD_W'(item.col) < hss_pkg::CRD_W'(hss_pkg::MAX_SIDE))
                      && (hss_pkg::CRD_W'(item.row) < hss_pkg::CRD_W'(hss_pkg::MAX_SIDE));

    // Saturated blend weight and near-far height difference
    assign w_sat = (weight_reg > hss_pkg::WEIGHT_W'(hss_pkg::ONE_Q16))
                 ? hss_pkg::WEIGHT_W'(hss_pkg::ONE_Q16) : weight_reg;
    assign dh    = CW'(hn_reg) - CW'(hf_reg);

    // Slope brightness: 1 - (w * (near - far) + far - centre) / 512, rounded to Q1.15 and clamped
    assign t_val  = TW'(hss_pkg::ONE_Q25) - TW'(prod_reg)
                  - (TW'(base_reg) <<< hss_pkg::Q16_SHIFT);
    assign r_wide = (t_val + TW'(hss_pkg::HALF_LSB)) >>> hss_pkg::FRAC_SHIFT;

    always_comb
    begin
        priority if (t_val < 0 || r_wide < TW'(hss_pkg::MIN_BRIGHT_Q15))
        begin
            slope_bright = BW'(hss_pkg::MIN_BRIGHT_Q15);
        end
        else if (r_wide > TW'(hss_pkg::ONE_Q15))
        begin
            slope_bright = BW'(hss_pkg::ONE_Q15);
        end
        else
        begin
            slope_bright = r_wide[BW-1:0];
        end
    end

    // Fallback needs the divider only strictly inside the height range
    assign div_needed = (den_reg > 0) && (num_reg > 0) && (num_reg < den_reg);

    assign out_load = (state_reg == hss_pkg::ST_DONE) && (!out_valid_reg || result.ready);

    // Advance the sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hss_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state, store access and divider start
    always_comb
    begin
        state_next      = state_reg;
        store_req       = '0;
        div_start       = 1'b0;
        unique case (state_reg)
            hss_pkg::ST_IDLE:
            begin
                if (item.valid)
                begin
                    if (item.kind == hss_pkg::KIND_QUERY)
                    begin
                        state_next = hss_pkg::ST_CHECK;
                    end
                    else
                    begin
                        store_req.we    = wr_in_range;
                        store_req.addr  = hss_pkg::pt_addr(hss_pkg::crd_t'(item.col),
                                                           hss_pkg::crd_t'(item.row));
                        store_req.wdata = hss_pkg::height_t'(item.height_in);
                    end
                end
            end
            hss_pkg::ST_CHECK:
            begin
                store_req.re   = 1'b1;
                store_req.addr = hss_pkg::pt_addr(x_reg, z_reg);
                state_next     = q_ok ? hss_pkg::ST_RD_N : hss_pkg::ST_DONE;
            end
            hss_pkg::ST_RD_N:
            begin
                if (pts_ok_reg)
                begin
                    store_req.re   = 1'b1;
                    store_req.addr = addr_n_reg;
                    state_next     = hss_pkg::ST_RD_F;
                end
                else
                begin
                    state_next = hss_pkg::ST_FALL;
                end
            end
            hss_pkg::ST_RD_F:
            begin
                store_req.re   = 1'b1;
                store_req.addr = addr_f_reg;
                state_next     = hss_pkg::ST_CAP_F;
            end
            hss_pkg::ST_CAP_F: state_next = hss_pkg::ST_MUL;
            hss_pkg::ST_MUL:   state_next = hss_pkg::ST_SUM;
            hss_pkg::ST_SUM:   state_next = hss_pkg::ST_DONE;
            hss_pkg::ST_FALL:  state_next = hss_pkg::ST_FCHK;
            hss_pkg::ST_FCHK:
            begin
                if (div_needed)
                begin
                    div_start  = 1'b1;
                    state_next = hss_pkg::ST_DIV;
                end
                else
                begin
                    state_next = hss_pkg::ST_DONE;
                end
            end
            hss_pkg::ST_DIV:
            begin
                if (!div_busy)
                begin
                    state_next = hss_pkg::ST_DONE;
                end
            end
            hss_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = hss_pkg::ST_IDLE;
                end
            end
            default: state_next = hss_pkg::ST_IDLE;
        endcase
    end

    // Capture operands and results step by step
    always_ff @(posedge clk)
    begin
        if (state_reg == hss_pkg::ST_IDLE && item.valid)
        begin
            x_reg <= hss_pkg::crd_t'(item.col);
            z_reg <= hss_pkg::crd_t'(item.row);
        end
        if (state_reg == hss_pkg::ST_CHECK)
        begin
            pts_ok_reg     <= pts_ok;
            addr_n_reg     <= hss_pkg::pt_addr(x0, z0);
            addr_f_reg     <= hss_pkg::pt_addr(x1, z1);
            res_bright_reg <= '0;
            res_fb_reg     <= 1'b1;
        end
        if (state_reg == hss_pkg::ST_RD_N)
        begin
            h_reg <= rdata;
        end
        if (state_reg == hss_pkg::ST_RD_F)
        begin
            hn_reg <= rdata;
        end
        if (state_reg == hss_pkg::ST_CAP_F)
        begin
            hf_reg <= rdata;
        end
        if (state_reg == hss_pkg::ST_MUL)
        begin
            prod_reg <= PW'(dh) * PW'($signed({1'b0, w_sat}));
            base_reg <= CW'(hf_reg) - CW'(h_reg);
        end
        if (state_reg == hss_pkg::ST_SUM)
        begin
            res_bright_reg <= slope_bright;
            res_fb_reg     <= 1'b0;
        end
        if (state_reg == hss_pkg::ST_FALL)
        begin
            num_reg <= CW'(h_reg) - CW'(low_reg);
            den_reg <= CW'(high_reg) - CW'(low_reg);
        end
        if (state_reg == hss_pkg::ST_FCHK)
        begin
            res_bright_reg <= (den_reg > 0 && num_reg > 0 && num_reg >= den_reg)
                            ? BW'(hss_pkg::ONE_Q15) : '0;
        end
        if (state_reg == hss_pkg::ST_DIV && !div_busy)
        begin
            res_bright_reg <= BW'(quot);
        end
        if (out_load)
        begin
            out_bright_reg <= res_bright_reg;
            out_fb_reg     <= res_fb_reg;
        end
    end

    // Hold a result beat until the receiver takes it
    assign out_valid_next = (out_valid_reg && !result.ready) || out_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign item.ready           = (state_reg == hss_pkg::ST_IDLE);
    assign result.valid         = out_valid_reg;
    assign result.brightness    = out_bright_reg;
    assign result.used_fallback = out_fb_reg;

    hss_store u_store (
        .clk   (clk),
        .req   (store_req),
        .rdata (rdata)
    );

    hss_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   ($unsigned(num_reg)),
        .den   ($unsigned(den_reg)),
        .busy  (div_busy),
        .quot  (quot)
    );

    // Slope results stay inside the clamp window
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.used_fallback |->
            result.brightness >= BW'(hss_pkg::MIN_BRIGHT_Q15) &&
            result.brightness <= BW'(hss_pkg::ONE_Q15))
        else $error("slope brightness outside clamp window");

    // No result ever exceeds full brightness
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.brightness <= BW'(hss_pkg::ONE_Q15))
        else $error("brightness above one");

    // A divider start always leads to a running divider
    assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> div_busy)
        else $error("divider failed to start");

    // No item is taken while the divider is still running
    assert property (@(posedge clk) disable iff (!rst_n)
        item.valid && item.ready |-> !div_busy)
        else $error("item accepted during divide");

endmodule
